// ===== sv/tbo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tbo_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int FIELD_W     = 32;
    localparam int N_CORNERS   = 3;
    localparam int N_IN_FIELDS = 10;
    localparam int IN_TDATA_W  = FIELD_W * N_IN_FIELDS;
    localparam int OUT_TDATA_W = 8;

    localparam int TOL_W = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

    // input field slots inside s_tdata
    localparam int FLD_BOX_LOW_X  = 6;
    localparam int FLD_BOX_LOW_Y  = 7;
    localparam int FLD_BOX_HIGH_X = 8;
    localparam int FLD_BOX_HIGH_Y = 9;

    // outcode bit positions
    localparam int OC_LEFT  = 0;
    localparam int OC_RIGHT = 1;
    localparam int OC_BELOW = 2;
    localparam int OC_ABOVE = 3;

    typedef logic [3:0] t_outcode;

    // result bit positions inside m_tdata
    localparam int RES_CROSSES  = 0;
    localparam int RES_INSIDE   = 1;
    localparam int RES_OVERLAPS = 2;

endpackage

`default_nettype wire

// ===== sv/tbo_edge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tbo_edge #(
    parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_en,
    input  wire signed [COORD_BITS-1:0]    i_xi,
    input  wire signed [COORD_BITS-1:0]    i_yi,
    input  wire signed [COORD_BITS-1:0]    i_xj,
    input  wire signed [COORD_BITS-1:0]    i_yj,
    input  wire signed [COORD_BITS:0]      i_mx2,
    input  wire signed [COORD_BITS:0]      i_my2,
    output logic signed [2*COORD_BITS+3:0] o_e
);

    localparam int DW = COORD_BITS + 1;
    localparam int UW = COORD_BITS + 2;
    localparam int PW = 2 * COORD_BITS + 3;
    localparam int EW = 2 * COORD_BITS + 4;

    logic signed [DW-1:0] r_dy, r_dx;
    logic signed [UW-1:0] r_ux, r_uy;
    logic signed [PW-1:0] r_p, r_q;
    logic signed [EW-1:0] r_e;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dy <= DW'(i_yi) - DW'(i_yj);
            r_dx <= DW'(i_xj) - DW'(i_xi);
            r_ux <= UW'(i_mx2) - (UW'(i_xi) <<< 1);
            r_uy <= UW'(i_my2) - (UW'(i_yi) <<< 1);
            r_p  <= PW'(r_dy) * PW'(r_ux);
            r_q  <= PW'(r_dx) * PW'(r_uy);
            r_e  <= EW'(r_p) + EW'(r_q);
        end
    end

    assign o_e = r_e;

endmodule

`default_nettype wire

// ===== sv/triangle_box_overlap_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted request passes through the edge stages, the magnitude/sum and bound stages and the output register.
// One request per cycle while the master side is not stalled; the edge multipliers are fully pipelined.
// A stall on the master side holds every stage in place until the result is taken.
// Reset (synchronous, active low) empties the pipeline and sets tolerance to 1.

module triangle_box_overlap_test #(
    parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tbo_pkg::FRAC_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
    // box_low_x, box_low_y, box_high_x, box_high_y (32 bits each)
    input  wire  [tbo_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    // edge_crosses, center_inside, overlaps, zero fill
    output logic [tbo_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [tbo_pkg::TOL_W-1:0]         i_cfg_data
);

    localparam int C   = COORD_BITS;
    localparam int FW  = tbo_pkg::FIELD_W;
    localparam int TW  = tbo_pkg::TOL_W;
    localparam int EW  = 2 * C + 4;
    localparam int MW  = 2 * C + 3;
    localparam int SW  = 2 * C + 5;
    localparam int PW  = SW + TW;
    localparam int UW  = TW + 2 * FRAC_BITS + 1;
    localparam int BW  = (PW > UW) ? PW : UW;
    localparam int NS  = 5;

    logic w_en, w_acc;
    logic [TW-1:0] r_tol;

    logic signed [C-1:0] w_cx [3];
    logic signed [C-1:0] w_cy [3];
    logic signed [C-1:0] w_lx, w_ly, w_hx, w_hy;
    logic signed [C:0]   w_mx2, w_my2;
    tbo_pkg::t_outcode   w_code [3];
    logic                w_cross;

    logic [NS:1] r_vld, r_cross;

    logic signed [EW-1:0] w_e [3];
    logic [MW-1:0]        n_mag [3];
    logic [MW-1:0]        r_mag4 [3], r_mag5 [3];
    logic [2:0]           r_neg4, r_neg5;
    logic [SW-1:0]        r_sum;
    logic [BW-1:0]        w_unit, w_sum_sh, w_prod, r_bound;
    logic [2:0]           w_gt;
    logic                 w_above, w_below, w_inside;

    logic                                   r_out_vld;
    logic [tbo_pkg::OUT_TDATA_W-1:0]        r_out_data;
    logic [tbo_pkg::OUT_TDATA_W-1:0]        n_out_data;

    assign w_en        = !r_out_vld || i_m_tready;
    assign o_s_tready  = w_en;
    assign w_acc       = i_s_tvalid && w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= tbo_pkg::TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_cx[k] = C'($signed(i_s_tdata[FW*(2*k) +: FW]));
            w_cy[k] = C'($signed(i_s_tdata[FW*(2*k+1) +: FW]));
        end
    end

    assign w_lx = C'($signed(i_s_tdata[FW*tbo_pkg::FLD_BOX_LOW_X  +: FW]));
    assign w_ly = C'($signed(i_s_tdata[FW*tbo_pkg::FLD_BOX_LOW_Y  +: FW]));
    assign w_hx = C'($signed(i_s_tdata[FW*tbo_pkg::FLD_BOX_HIGH_X +: FW]));
    assign w_hy = C'($signed(i_s_tdata[FW*tbo_pkg::FLD_BOX_HIGH_Y +: FW]));

    assign w_mx2 = (C+1)'(w_lx) + (C+1)'(w_hx);
    assign w_my2 = (C+1)'(w_ly) + (C+1)'(w_hy);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_code[k] = '0;
            w_code[k][tbo_pkg::OC_LEFT]  = w_cx[k] < w_lx;
            w_code[k][tbo_pkg::OC_RIGHT] = w_cx[k] > w_hx;
            w_code[k][tbo_pkg::OC_BELOW] = w_cy[k] < w_ly;
            w_code[k][tbo_pkg::OC_ABOVE] = w_cy[k] > w_hy;
        end
        w_cross = ((w_code[0] & w_code[1]) == '0) || ((w_code[1] & w_code[2]) == '0) ||
                  ((w_code[2] & w_code[0]) == '0);
    end

    for (genvar g = 0; g < 3; g++) begin : g_edge
        tbo_edge #(
            .COORD_BITS(COORD_BITS)
        ) u_edge (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_xi  (w_cx[g]),
            .i_yi  (w_cy[g]),
            .i_xj  (w_cx[(g+1)%3]),
            .i_yj  (w_cy[(g+1)%3]),
            .i_mx2 (w_mx2),
            .i_my2 (w_my2),
            .o_e   (w_e[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-1:1], w_acc};
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = w_e[k][EW-1] ? MW'(-w_e[k]) : MW'(w_e[k]);
        end
    end

    assign w_unit   = BW'(r_tol) << (2 * FRAC_BITS + 1);
    assign w_sum_sh = BW'({r_sum, {TW{1'b0}}});
    assign w_prod   = BW'(PW'(r_sum) * PW'(r_tol));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_gt[k] = BW'({r_mag5[k], {TW{1'b0}}}) > r_bound;
        end
        w_above  = |(w_gt & ~r_neg5);
        w_below  = |(w_gt & r_neg5);
        w_inside = !(w_above && w_below);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cross <= {r_cross[NS-1:1], w_cross};
            for (int k = 0; k < 3; k++) begin
                r_mag4[k] <= n_mag[k];
                r_neg4[k] <= w_e[k][EW-1];
                r_mag5[k] <= r_mag4[k];
            end
            r_sum   <= SW'(n_mag[0]) + SW'(n_mag[1]) + SW'(n_mag[2]);
            r_neg5  <= r_neg4;
            r_bound <= (w_sum_sh < w_unit) ? w_unit : w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[NS];
        end
    end

    always_comb begin
        n_out_data                        = '0;
        n_out_data[tbo_pkg::RES_CROSSES]  = r_cross[NS];
        n_out_data[tbo_pkg::RES_INSIDE]   = w_inside;
        n_out_data[tbo_pkg::RES_OVERLAPS] = r_cross[NS] || w_inside;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    a_overlap_or : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_data[tbo_pkg::RES_OVERLAPS] ==
                       (r_out_data[tbo_pkg::RES_CROSSES] || r_out_data[tbo_pkg::RES_INSIDE])))
        else $error("overlaps flag is not the OR of the other two");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |=> $stable(r_vld))
        else $error("pipeline moved during output stall");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_vld && (r_vld == '0)))
        else $error("pipeline not empty after reset");

    a_entry_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && $past(i_rst_n)) |->
            ($past(i_s_tvalid && w_en) || $past(r_vld[1] && !w_en)))
        else $error("first stage valid without an accepted request");

endmodule

`default_nettype wire
